FILE: sv/calendar_to_epoch_seconds_assert.svh
// Assertion macros shared by the calendar_to_epoch_seconds RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH
`define CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CES_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ces_pkg.sv
// Shared widths, constants, stage payload types and helper functions
// for the calendar to epoch seconds pipeline. No dependencies.
package ces_pkg;

    localparam int YearW   = 14;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinW    = 6;
    localparam int SecW    = 6;
    localparam int NsW     = 30;
    localparam int EpochW  = 38;
    localparam int UsecW   = 20;

    localparam int DaysW   = 23;   // day count for years up to 16383
    localparam int TodW    = 17;   // seconds within a day, unchecked fields
    localparam int MdaysW  = 9;    // days before the month
    localparam int QuotW   = 8;    // quotient of a 12-bit value by 25
    localparam int UsecQW  = 21;   // unsaturated nanosecond / 1000
    localparam int SecsW   = DaysW + TodW;

    localparam logic [YearW-1:0] EpochYear = YearW'(1970);
    // Leap years in 1..1969
    localparam int LeapsBeforeEpoch = 477;
    localparam int SecsPerDay = 86400;
    localparam int MaxUsec = 999999;

    // x / 25 for x below 4096: floor(x * 5243 / 2^17)
    localparam int Div25Mul   = 5243;
    localparam int Div25Shift = 17;
    localparam int Div25PW    = 12 + 13;

    // x / 125 for x below 2^27: floor(x * 137438954 / 2^34)
    localparam int UsecMul    = 137438954;
    localparam int UsecShift  = 34;
    localparam int UsecInW    = NsW - 3;
    localparam int UsecPW     = UsecInW + 28;

    typedef struct packed {
        logic                 after_epoch;
        logic [YearW-1:0]     year_off;
        logic [11:0]          prev_div4;
        logic [QuotW-1:0]     prev_div100;
        logic [QuotW-1:0]     prev_div400;
        logic [YearW-1:0]     year;
        logic [QuotW-1:0]     year_q100;
        logic [QuotW-1:0]     year_q400;
        logic [MdaysW-1:0]    mdays;
        logic                 past_feb;
        logic [DayW-1:0]      day_off;
        logic [TodW-1:0]      tod;
        logic [UsecQW-1:0]    usec_q;
    } front_t;

    typedef struct packed {
        logic [DaysW-1:0]     days;
        logic [TodW-1:0]      tod;
        logic [UsecW-1:0]     usec;
    } days_t;

    function automatic logic [QuotW-1:0] div25(input logic [11:0] x);
        logic [Div25PW-1:0] p;
        p = Div25PW'(x) * Div25PW'(Div25Mul);
        return p[Div25Shift +: QuotW];
    endfunction

    // Days in the months before the given one, non-leap year
    function automatic logic [MdaysW-1:0] month_days(input logic [MonthW-1:0] m);
        logic [MdaysW-1:0] d;
        case (m) inside
            4'd2:           d = MdaysW'(31);
            4'd3:           d = MdaysW'(59);
            4'd4:           d = MdaysW'(90);
            4'd5:           d = MdaysW'(120);
            4'd6:           d = MdaysW'(151);
            4'd7:           d = MdaysW'(181);
            4'd8:           d = MdaysW'(212);
            4'd9:           d = MdaysW'(243);
            4'd10:          d = MdaysW'(273);
            4'd11:          d = MdaysW'(304);
            4'd12:          d = MdaysW'(334);
            [4'd13:4'd15]:  d = MdaysW'(365);
            default:        d = '0;
        endcase
        return d;
    endfunction

endpackage

FILE: sv/ces_front.sv
// First pipeline stage: constant-divisor quotients, month table lookup,
// time of day and the nanosecond reciprocal product. Uses ces_pkg.
module ces_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [ces_pkg::YearW-1:0]   year,
    input  logic [ces_pkg::MonthW-1:0]  month,
    input  logic [ces_pkg::DayW-1:0]    day,
    input  logic [ces_pkg::HourW-1:0]   hour,
    input  logic [ces_pkg::MinW-1:0]    minute,
    input  logic [ces_pkg::SecW-1:0]    second,
    input  logic [ces_pkg::NsW-1:0]     nanosecond,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output ces_pkg::front_t             dn_data
);
    import ces_pkg::*;

    logic               valid_reg;
    front_t             data_reg;
    front_t             data_next;
    logic [YearW-1:0]   prev_year;
    logic [UsecPW-1:0]  usec_prod;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        prev_year = year - YearW'(1);
        usec_prod = UsecPW'(nanosecond[NsW-1:3]) * UsecPW'(UsecMul);

        data_next.after_epoch = year > EpochYear;
        data_next.year_off    = year - EpochYear;
        data_next.prev_div4   = prev_year[YearW-1:2];
        data_next.prev_div100 = div25(prev_year[YearW-1:2]);
        data_next.prev_div400 = div25(12'(prev_year[YearW-1:4]));
        data_next.year        = year;
        data_next.year_q100   = div25(year[YearW-1:2]);
        data_next.year_q400   = div25(12'(year[YearW-1:4]));
        data_next.mdays       = month_days(month);
        data_next.past_feb    = month >= MonthW'(3);
        data_next.day_off     = (day == '0) ? '0 : day - DayW'(1);
        data_next.tod         = TodW'(hour) * TodW'(3600) + TodW'(minute) * TodW'(60)
                              + TodW'(second);
        data_next.usec_q      = usec_prod[UsecShift +: UsecQW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: sv/ces_days.sv
// Second pipeline stage: leap test, leap-year count, total day count
// and microsecond saturation. Uses ces_pkg.
module ces_days (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  ces_pkg::front_t     up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output ces_pkg::days_t      dn_data
);
    import ces_pkg::*;

    logic               valid_reg;
    days_t              data_reg;
    days_t              data_next;
    logic               div100;
    logic               div400;
    logic               leap;
    logic [DaysW-1:0]   leaps;
    logic [DaysW-1:0]   year_days;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        div100 = (up_data.year[1:0] == 2'd0)
              && (12'(up_data.year_q100) * 12'd25 == up_data.year[YearW-1:2]);
        div400 = (up_data.year[3:0] == 4'd0)
              && (12'(up_data.year_q400) * 12'd25 == 12'(up_data.year[YearW-1:4]));
        leap   = ((up_data.year[1:0] == 2'd0) && !div100) || div400;

        // leap years in 1..year-1, then drop those before the epoch
        leaps = DaysW'(up_data.prev_div4) - DaysW'(up_data.prev_div100)
              + DaysW'(up_data.prev_div400);
        year_days = up_data.after_epoch
                  ? DaysW'(up_data.year_off) * DaysW'(365) + leaps
                    - DaysW'(LeapsBeforeEpoch)
                  : '0;

        data_next.days = year_days + DaysW'(up_data.mdays)
                       + DaysW'(leap && up_data.past_feb) + DaysW'(up_data.day_off);
        data_next.tod  = up_data.tod;
        data_next.usec = (up_data.usec_q > UsecQW'(MaxUsec))
                       ? UsecW'(MaxUsec) : up_data.usec_q[UsecW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: sv/ces_scale.sv
// Third pipeline stage and output register: days times 86400 plus the
// time of day, wrapped to the result width. Uses ces_pkg.
module ces_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  ces_pkg::days_t              up_data,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output logic [ces_pkg::EpochW-1:0]  epoch_seconds,
    output logic [ces_pkg::UsecW-1:0]   microseconds
);
    import ces_pkg::*;

    logic               valid_reg;
    logic [EpochW-1:0]  secs_reg;
    logic [UsecW-1:0]   usec_reg;
    logic [SecsW-1:0]   secs_next;

    assign up_ready      = !valid_reg || dn_ready;
    assign dn_valid      = valid_reg;
    assign epoch_seconds = secs_reg;
    assign microseconds  = usec_reg;

    assign secs_next = SecsW'(up_data.days) * SecsW'(SecsPerDay) + SecsW'(up_data.tod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            secs_reg <= secs_next[EpochW-1:0];
            usec_reg <= up_data.usec;
        end
    end

endmodule

FILE: sv/calendar_to_epoch_seconds.sv
// Calendar date and time to epoch seconds and microseconds.
// An accepted transaction passes through the front, days and scale registers to the outputs.
// Throughput: one transaction per cycle; the three register stages advance
// together and collapse bubbles, so req_stall rises only when all are full.
// Reset clears the stage valid bits at once; no payload is reset.
`include "calendar_to_epoch_seconds_assert.svh"

module calendar_to_epoch_seconds (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [ces_pkg::YearW-1:0]   year,
    input  logic [ces_pkg::MonthW-1:0]  month,
    input  logic [ces_pkg::DayW-1:0]    day,
    input  logic [ces_pkg::HourW-1:0]   hour,
    input  logic [ces_pkg::MinW-1:0]    minute,
    input  logic [ces_pkg::SecW-1:0]    second,
    input  logic [ces_pkg::NsW-1:0]     nanosecond,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [ces_pkg::EpochW-1:0]  epoch_seconds,
    output logic [ces_pkg::UsecW-1:0]   microseconds
);
    import ces_pkg::*;

    logic       front_ready;
    logic       front_valid;
    front_t     front_data;
    logic       days_ready;
    logic       days_valid;
    days_t      days_data;
    logic       scale_ready;

    assign req_stall = !front_ready;

    ces_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (req_valid),
        .up_ready   (front_ready),
        .year       (year),
        .month      (month),
        .day        (day),
        .hour       (hour),
        .minute     (minute),
        .second     (second),
        .nanosecond (nanosecond),
        .dn_valid   (front_valid),
        .dn_ready   (days_ready),
        .dn_data    (front_data)
    );

    ces_days u_days (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (front_valid),
        .up_ready   (days_ready),
        .up_data    (front_data),
        .dn_valid   (days_valid),
        .dn_ready   (scale_ready),
        .dn_data    (days_data)
    );

    ces_scale u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (days_valid),
        .up_ready       (scale_ready),
        .up_data        (days_data),
        .dn_valid       (rsp_valid),
        .dn_ready       (!rsp_stall),
        .epoch_seconds  (epoch_seconds),
        .microseconds   (microseconds)
    );

    // Accepted transaction lands in the first stage
    `CES_ASSERT_NEXT(a_accept_enters, req_valid && !req_stall, front_valid, "accepted transaction lost")
    // Backpressure only with every stage occupied
    `CES_ASSERT_IMPL(a_stall_full, req_stall, front_valid && days_valid && rsp_valid && rsp_stall, "stall with room in pipeline")
    // Output drains when nothing follows it
    `CES_ASSERT_NEXT(a_drain, rsp_valid && !rsp_stall && !days_valid, !rsp_valid, "result repeated")
    // Saturated microsecond range
    `CES_ASSERT_IMPL(a_usec_range, rsp_valid, microseconds <= UsecW'(MaxUsec), "microseconds out of range")

endmodule
